### rtl/sfhm_pkg.sv
package sfhm_pkg;

	// fixed field widths
	localparam int SID_W    = 8;
	localparam int TS_W     = 63;
	localparam int THR_W    = 47;
	localparam int GAP_W    = 48;
	localparam int RATE_W   = 17;
	localparam int TOTAL_W  = 32;
	localparam int STATUS_W = 2;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1000000000);

	// parameter defaults
	localparam int NUM_SOURCES_DEF    = 256;
	localparam int COUNT_BITS_DEF     = 32;
	localparam int RATE_FRAC_BITS_DEF = 16;

	typedef enum logic [STATUS_W-1:0] {
		HEALTH_NONE     = 2'd0,
		HEALTH_OK       = 2'd1,
		HEALTH_DEGRADED = 2'd2
	} sfhm_health_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_UPDATE,
		S_GAP,
		S_DIV_GO,
		S_DIV_WAIT,
		S_FINISH
	} sfhm_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sfhm_div_stat_t;

endpackage

### rtl/source_feed_health_monitor.sv
// channel | direction | handshake            | payload
// --------+-----------+----------------------+------------------------------------------
// in      | input     | in_valid / in_ready  | source_id, timestamp_ns, three flag bits
// out     | output    | out_valid / out_ready| source_echo, status, gap_ns, totals, rates
// cfg     | input     | cfg_we               | cfg_wdata (stale_gap_ns)
//
// one beat at a time: accept, update, gap check, four divisions, finish
// each division runs on one shared radix-2 divider: a count at or above the event total
// is clamped to one, else the divider works out the quotient in its restoring steps
// after reset a clearing pass writes every entry of the counter store, with in_ready low
// the output register holds a result while the next beat is already being worked
// a stalled output holds the engine in its finish step until the register frees
module source_feed_health_monitor #(
	parameter int NUM_SOURCES    = sfhm_pkg::NUM_SOURCES_DEF,
	parameter int COUNT_BITS     = sfhm_pkg::COUNT_BITS_DEF,
	parameter int RATE_FRAC_BITS = sfhm_pkg::RATE_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [sfhm_pkg::THR_W-1:0]         cfg_wdata,
	// event input
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [sfhm_pkg::SID_W-1:0]         source_id,
	input  logic [sfhm_pkg::TS_W-1:0]          timestamp_ns,
	input  logic                               seq_gap_flag,
	input  logic                               duplicate_flag,
	input  logic                               out_of_order_flag,
	// health result
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [sfhm_pkg::SID_W-1:0]         source_echo,
	output logic [sfhm_pkg::STATUS_W-1:0]      status,
	output logic signed [sfhm_pkg::GAP_W-1:0]  gap_ns,
	output logic [sfhm_pkg::TOTAL_W-1:0]       event_total,
	output logic [sfhm_pkg::RATE_W-1:0]        stale_ratio,
	output logic [sfhm_pkg::RATE_W-1:0]        gap_rate,
	output logic [sfhm_pkg::RATE_W-1:0]        dup_ratio,
	output logic [sfhm_pkg::RATE_W-1:0]        late_rate,
	output logic [sfhm_pkg::RATE_W-1:0]        reliability,
	output logic                               stale_flag,
	output logic                               usable
);
	import sfhm_pkg::*;

	localparam int IDX_BITS = $clog2(NUM_SOURCES);
	localparam int CB       = COUNT_BITS;
	localparam int F        = RATE_FRAC_BITS;
	// counter record: health, seen, late, dup, gap, stale, events
	localparam int REC_W    = 5 * CB + 3;
	localparam int SID_SPAN = 1 << SID_W;
	localparam logic [F:0] HALF = (F+1)'(1) << (F - 1);

	function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	// source index to store entry, modulo the store depth
	logic [IDX_BITS-1:0] idx_tab [SID_SPAN];
	for (genvar i = 0; i < SID_SPAN; i++) begin : g_idx
		assign idx_tab[i] = IDX_BITS'(i % NUM_SOURCES);
	end

	sfhm_state_t state_q, state_d;

	logic [THR_W-1:0]    thr_q;
	logic [IDX_BITS-1:0] clr_q;
	logic [IDX_BITS-1:0] idx_q;
	logic [SID_W-1:0]    sid_q;
	logic [TS_W-1:0]     now_q;
	logic [2:0]          flags_q;
	logic [TS_W:0]       fwd_q;
	logic [1:0]          sel_q;

	logic [CB-1:0] ev_q, st_q, gp_q, dp_q, lt_q;
	sfhm_health_t  health_q;
	logic [GAP_W-1:0] gap_q;
	logic [F:0]    sr_q, gr_q, dr_q, lr_q;

	// output register
	logic                out_valid_q;
	logic [SID_W-1:0]    echo_q;
	logic [STATUS_W-1:0] status_q;
	logic [GAP_W-1:0]    gap_out_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [RATE_W-1:0]   sr_out_q, gr_out_q, dr_out_q, lr_out_q, rel_out_q;
	logic                stale_out_q, usable_q;

	// control from the sequencer
	logic accept, div_start, out_load;

	// store ports
	logic                cnt_we;
	logic [IDX_BITS-1:0] cnt_waddr, rd_addr;
	logic [REC_W-1:0]    cnt_wdata, cnt_rdata, rec_n;
	logic                last_we;
	logic [TS_W-1:0]     last_rdata;

	// fields of the stored record
	logic [CB-1:0] ev_o, st_o, gp_o, dp_o, lt_o;
	logic          seen_o;
	logic [1:0]    health_o;

	// gap check
	logic          neg, stale;
	logic [CB-1:0] ev_n, st_n, gp_n, dp_n, lt_n;
	sfhm_health_t  health_n;
	logic [GAP_W-1:0] gap_n;

	// divider
	sfhm_div_stat_t div_st;
	logic [CB-1:0]  div_num;
	logic [F:0]     div_quot;

	// finish
	logic [F+2:0]  two_one, sub, rel_w;
	logic [F:0]    rel;
	logic [CB+3:0] st_x10;
	logic [63:0]   ev64;

	assign {health_o, seen_o, lt_o, dp_o, gp_o, st_o, ev_o} = cnt_rdata;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == IDX_BITS'(NUM_SOURCES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: state_d = S_GAP;
			S_GAP:    state_d = S_DIV_GO;
			S_DIV_GO: begin
				div_start = 1'b1;
				state_d   = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (div_st.done) begin
					state_d = (sel_q == 2'd3) ? S_FINISH : S_DIV_GO;
				end
			end
			S_FINISH: begin
				// wait for the output register to free
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	assign accept = in_valid && in_ready;

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_RESET;
			clr_q       <= '0;
			sel_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_GAP) begin
				sel_q <= '0;
			end else if (state_q == S_DIV_WAIT && div_st.done) begin
				sel_q <= sel_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- stores ----------------
	assign rd_addr   = (state_q == S_IDLE) ? idx_tab[source_id] : idx_q;
	assign cnt_we    = (state_q == S_CLEAR) || (state_q == S_GAP);
	assign cnt_waddr = (state_q == S_CLEAR) ? clr_q : idx_q;
	assign cnt_wdata = (state_q == S_CLEAR) ? '0 : rec_n;
	assign last_we   = (state_q == S_GAP);

	sfhm_ram #(.WIDTH(REC_W), .DEPTH(NUM_SOURCES)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (rd_addr),
		.rdata (cnt_rdata)
	);

	// last arrival time, only used once the source has been seen
	sfhm_ram #(.WIDTH(TS_W), .DEPTH(NUM_SOURCES)) u_last_ram (
		.clk   (clk),
		.we    (last_we),
		.waddr (idx_q),
		.wdata (now_q),
		.raddr (rd_addr),
		.rdata (last_rdata)
	);

	// ---------------- gap check and counter update ----------------
	assign neg   = fwd_q[TS_W];
	assign stale = seen_o && !neg && (fwd_q[TS_W-1:0] > {{(TS_W-THR_W){1'b0}}, thr_q});

	always_comb begin
		ev_n = sat_inc(ev_o);
		st_n = stale      ? sat_inc(st_o) : st_o;
		gp_n = flags_q[2] ? sat_inc(gp_o) : gp_o;
		dp_n = flags_q[1] ? sat_inc(dp_o) : dp_o;
		lt_n = flags_q[0] ? sat_inc(lt_o) : lt_o;
		if (!seen_o) begin
			// first beat of a source keeps its status
			health_n = sfhm_health_t'(health_o);
			gap_n    = '0;
		end else if (neg) begin
			// backwards in time: healthy, gap clamped at minus 2^47
			health_n = HEALTH_OK;
			gap_n    = (&fwd_q[TS_W:GAP_W-1]) ? fwd_q[GAP_W-1:0]
				: {1'b1, {(GAP_W-1){1'b0}}};
		end else begin
			health_n = stale ? HEALTH_DEGRADED : HEALTH_OK;
			gap_n    = (|fwd_q[TS_W-1:GAP_W-1]) ? {1'b0, {(GAP_W-1){1'b1}}}
				: fwd_q[GAP_W-1:0];
		end
	end

	assign rec_n = {health_n, 1'b1, lt_n, dp_n, gp_n, st_n, ev_n};

	// ---------------- divisions ----------------
	always_comb begin
		case (sel_q)
			2'd0:    div_num = st_q;
			2'd1:    div_num = gp_q;
			2'd2:    div_num = dp_q;
			default: div_num = lt_q;
		endcase
	end

	sfhm_div #(.COUNT_BITS(CB), .RATE_FRAC_BITS(F)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (ev_q),
		.stat   (div_st),
		.quot   (div_quot)
	);

	// ---------------- finish ----------------
	assign two_one = (F+3)'(1) << (F + 1);
	assign sub     = {1'b0, sr_q, 1'b0} + {2'b00, gr_q};
	assign rel_w   = (sub >= two_one) ? '0 : ((two_one - sub) >> 1);
	assign rel     = rel_w[F:0];
	assign st_x10  = {1'b0, st_q, 3'b000} + {3'b000, st_q, 1'b0};
	assign ev64    = 64'(ev_q);

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q   <= idx_tab[source_id];
			sid_q   <= source_id;
			now_q   <= timestamp_ns;
			flags_q <= {seq_gap_flag, duplicate_flag, out_of_order_flag};
		end
		if (state_q == S_UPDATE) begin
			fwd_q <= {1'b0, now_q} - {1'b0, last_rdata};
		end
		if (state_q == S_GAP) begin
			ev_q     <= ev_n;
			st_q     <= st_n;
			gp_q     <= gp_n;
			dp_q     <= dp_n;
			lt_q     <= lt_n;
			health_q <= health_n;
			gap_q    <= gap_n;
		end
		if (state_q == S_DIV_WAIT && div_st.done) begin
			case (sel_q)
				2'd0:    sr_q <= div_quot;
				2'd1:    gr_q <= div_quot;
				2'd2:    dr_q <= div_quot;
				default: lr_q <= div_quot;
			endcase
		end
		if (out_load) begin
			echo_q      <= sid_q;
			status_q    <= health_q;
			gap_out_q   <= gap_q;
			total_q     <= (ev64 > 64'h0000_0000_FFFF_FFFF) ? '1 : ev64[TOTAL_W-1:0];
			sr_out_q    <= RATE_W'(sr_q);
			gr_out_q    <= RATE_W'(gr_q);
			dr_out_q    <= RATE_W'(dr_q);
			lr_out_q    <= RATE_W'(lr_q);
			rel_out_q   <= RATE_W'(rel);
			stale_out_q <= st_x10 > {4'b0000, ev_q};
			usable_q    <= rel > HALF;
		end
	end

	assign out_valid      = out_valid_q;
	assign source_echo    = echo_q;
	assign status         = status_q;
	assign gap_ns         = gap_out_q;
	assign event_total    = total_q;
	assign stale_ratio    = sr_out_q;
	assign gap_rate       = gr_out_q;
	assign dup_ratio      = dr_out_q;
	assign late_rate      = lr_out_q;
	assign reliability    = rel_out_q;
	assign stale_flag     = stale_out_q;
	assign usable         = usable_q;

`ifndef SYNTHESIS
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second beat taken while one is in work");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider restarted while busy");
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) && !out_valid_q |=> out_valid_q && (state_q == S_IDLE))
		else $error("finished result not presented");
`endif

endmodule

### rtl/sfhm_ram.sv
module sfhm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/sfhm_div.sv
module sfhm_div #(
	parameter int COUNT_BITS     = 32,
	parameter int RATE_FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [COUNT_BITS-1:0]       num,
	input  logic [COUNT_BITS-1:0]       den,
	output sfhm_pkg::sfhm_div_stat_t    stat,
	output logic [RATE_FRAC_BITS:0]     quot
);
	import sfhm_pkg::*;

	localparam int CNT_W = $clog2(RATE_FRAC_BITS + 1);
	localparam logic [RATE_FRAC_BITS:0] ONE = (RATE_FRAC_BITS+1)'(1) << RATE_FRAC_BITS;

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [COUNT_BITS-1:0]   rem_q;
	logic [RATE_FRAC_BITS:0] quot_q;

	logic [COUNT_BITS:0] rem_sh;
	logic                take;

	// one restoring step
	assign rem_sh = {rem_q, 1'b0};
	assign take   = rem_sh >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (num >= den) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(RATE_FRAC_BITS);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			quot_q <= (num >= den) ? ONE : '0;
		end else if (busy_q) begin
			rem_q  <= take ? COUNT_BITS'(rem_sh - {1'b0, den}) : COUNT_BITS'(rem_sh);
			quot_q <= {quot_q[RATE_FRAC_BITS-1:0], take};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		start && (num >= den) |=> done_q && (quot_q == ONE))
		else $error("clamped quotient not delivered");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> quot_q <= ONE)
		else $error("quotient above one");
`endif

endmodule

### test/sfhm_checker.sv
module sfhm_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sfhm_pkg::THR_W-1:0]         cfg_wdata,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [sfhm_pkg::SID_W-1:0]         source_id,
	input  logic [sfhm_pkg::TS_W-1:0]          timestamp_ns,
	input  logic                               seq_gap_flag,
	input  logic                               duplicate_flag,
	input  logic                               out_of_order_flag,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [sfhm_pkg::SID_W-1:0]         source_echo,
	input  logic [sfhm_pkg::STATUS_W-1:0]      status,
	input  logic signed [sfhm_pkg::GAP_W-1:0]  gap_ns,
	input  logic [sfhm_pkg::TOTAL_W-1:0]       event_total,
	input  logic [sfhm_pkg::RATE_W-1:0]        stale_ratio,
	input  logic [sfhm_pkg::RATE_W-1:0]        gap_rate,
	input  logic [sfhm_pkg::RATE_W-1:0]        dup_ratio,
	input  logic [sfhm_pkg::RATE_W-1:0]        late_rate,
	input  logic [sfhm_pkg::RATE_W-1:0]        reliability,
	input  logic                               stale_flag,
	input  logic                               usable,
	output int                                 outstanding,
	output int                                 fail_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import sfhm_pkg::*;

	localparam int N_SRC = NUM_SOURCES_DEF;
	localparam int RATE_ONE = 1 << RATE_FRAC_BITS_DEF;
	localparam logic [GAP_W-1:0] GAP_POS_MAX = {1'b0, {(GAP_W-1){1'b1}}};
	localparam logic [63:0] GAP_NEG_MAG = 64'h0000_8000_0000_0000;

	typedef struct packed {
		logic [SID_W-1:0]   sid;
		sfhm_health_t       st;
		logic [GAP_W-1:0]   gap;
		logic [TOTAL_W-1:0] total;
		logic [RATE_W-1:0]  sr;
		logic [RATE_W-1:0]  gr;
		logic [RATE_W-1:0]  dr;
		logic [RATE_W-1:0]  lr;
		logic [RATE_W-1:0]  rel;
		logic               stale;
		logic               usable;
	} health_report_t;

	// per-source shadow of the block's store
	logic [31:0]      ev_cnt     [N_SRC];
	logic [31:0]      stale_cnt  [N_SRC];
	logic [31:0]      seqgap_cnt [N_SRC];
	logic [31:0]      dup_cnt    [N_SRC];
	logic [31:0]      late_cnt   [N_SRC];
	logic [TS_W-1:0]  last_ts    [N_SRC];
	logic             seen       [N_SRC];
	sfhm_health_t     health     [N_SRC];
	logic [THR_W-1:0] stale_thr;

	health_report_t report_q[$];

	function automatic logic [31:0] bump(logic [31:0] c);
		return (c == '1) ? c : c + 32'd1;
	endfunction

	// truncated count/events in q1.16, clamped to one
	function automatic logic [RATE_W-1:0] q16_ratio(logic [31:0] num, logic [31:0] den);
		logic [63:0] wide;
		if (num >= den)
			return RATE_W'(RATE_ONE);
		wide = {32'd0, num} << RATE_FRAC_BITS_DEF;
		return RATE_W'(wide / {32'd0, den});
	endfunction

	task automatic predict_health(input logic [SID_W-1:0] sid, input logic [TS_W-1:0] now,
			input logic sg, input logic du, input logic oo, output health_report_t r);
		int s;
		int sub;
		int rel;
		logic [63:0] diff;
		logic [GAP_W-1:0] gap;
		logic [31:0] ev;
		s = int'(sid) % N_SRC;
		gap = '0;
		ev_cnt[s] = bump(ev_cnt[s]);
		if (seen[s]) begin
			if (now >= last_ts[s]) begin
				diff = {1'b0, TS_W'(now - last_ts[s])};
				// stale test on the exact gap, before clamping
				if (diff > {17'd0, stale_thr}) begin
					health[s] = HEALTH_DEGRADED;
					stale_cnt[s] = bump(stale_cnt[s]);
				end else begin
					health[s] = HEALTH_OK;
				end
				gap = (diff > {16'd0, GAP_POS_MAX}) ? GAP_POS_MAX : diff[GAP_W-1:0];
			end else begin
				diff = {1'b0, TS_W'(last_ts[s] - now)};
				if (diff > GAP_NEG_MAG)
					diff = GAP_NEG_MAG;
				health[s] = HEALTH_OK;
				gap = GAP_W'(64'd0 - diff);
			end
		end
		last_ts[s] = now;
		seen[s] = 1'b1;
		if (sg)
			seqgap_cnt[s] = bump(seqgap_cnt[s]);
		if (du)
			dup_cnt[s] = bump(dup_cnt[s]);
		if (oo)
			late_cnt[s] = bump(late_cnt[s]);
		ev = ev_cnt[s];
		r.sid = sid;
		r.st = health[s];
		r.gap = (health[s] != HEALTH_NONE) ? gap : '0;
		r.total = ev;
		r.sr = q16_ratio(stale_cnt[s], ev);
		r.gr = q16_ratio(seqgap_cnt[s], ev);
		r.dr = q16_ratio(dup_cnt[s], ev);
		r.lr = q16_ratio(late_cnt[s], ev);
		sub = 2 * int'(r.sr) + int'(r.gr);
		rel = (sub >= 2 * RATE_ONE) ? 0 : (2 * RATE_ONE - sub) >> 1;
		r.rel = RATE_W'(rel);
		r.stale = ({32'd0, stale_cnt[s]} * 64'd10 > {32'd0, ev});
		r.usable = (rel > RATE_ONE / 2);
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		health_report_t fresh;
		health_report_t oldest;
		if (!arst_n) begin
			for (int i = 0; i < N_SRC; i++) begin
				ev_cnt[i] = '0;
				stale_cnt[i] = '0;
				seqgap_cnt[i] = '0;
				dup_cnt[i] = '0;
				late_cnt[i] = '0;
				last_ts[i] = '0;
				seen[i] = 1'b0;
				health[i] = HEALTH_NONE;
			end
			stale_thr = THR_RESET;
			report_q.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we)
				stale_thr = cfg_wdata;
			if (out_valid && out_ready) begin
				if (report_q.size() == 0) begin
					$display("%0t ns: unexpected result beat, expected none, actual source %0d",
						$time, source_echo);
					fail_count++;
				end else begin
					oldest = report_q.pop_front();
					check_field("source_echo", 64'(oldest.sid), 64'(source_echo));
					check_field("status", 64'(oldest.st), 64'(status));
					check_field("gap_ns", 64'(oldest.gap), 64'($unsigned(gap_ns)));
					check_field("event_total", 64'(oldest.total), 64'(event_total));
					check_field("stale_ratio", 64'(oldest.sr), 64'(stale_ratio));
					check_field("gap_rate", 64'(oldest.gr), 64'(gap_rate));
					check_field("dup_ratio", 64'(oldest.dr), 64'(dup_ratio));
					check_field("late_rate", 64'(oldest.lr), 64'(late_rate));
					check_field("reliability", 64'(oldest.rel), 64'(reliability));
					check_field("stale_flag", 64'(oldest.stale), 64'(stale_flag));
					check_field("usable", 64'(oldest.usable), 64'(usable));
				end
			end
			if (in_valid && in_ready) begin
				predict_health(source_id, timestamp_ns, seq_gap_flag, duplicate_flag,
					out_of_order_flag, fresh);
				report_q.push_back(fresh);
			end
			outstanding <= report_q.size();
		end
	end

endmodule

### test/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sfhm_pkg::*;

	// cycles with no beat on either channel before the run is declared hung;
	// covers the post-reset clearing pass plus the slowest item and stalls
	localparam int QUIET_LIMIT = 4000;
	localparam logic [TS_W-1:0] TS_MAX = '1;
	localparam logic [TS_W-1:0] TS_P47 = TS_W'(64'h0000_8000_0000_0000);
	localparam logic [63:0] GAP_SPAN = 64'h0000_8000_0000_0000;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [THR_W-1:0]         cfg_wdata;
	logic                     in_valid;
	logic                     in_ready;
	logic [SID_W-1:0]         source_id;
	logic [TS_W-1:0]          timestamp_ns;
	logic                     seq_gap_flag;
	logic                     duplicate_flag;
	logic                     out_of_order_flag;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [SID_W-1:0]         source_echo;
	logic [STATUS_W-1:0]      status;
	logic signed [GAP_W-1:0]  gap_ns;
	logic [TOTAL_W-1:0]       event_total;
	logic [RATE_W-1:0]        stale_ratio;
	logic [RATE_W-1:0]        gap_rate;
	logic [RATE_W-1:0]        dup_ratio;
	logic [RATE_W-1:0]        late_rate;
	logic [RATE_W-1:0]        reliability;
	logic                     stale_flag;
	logic                     usable;
	int                       outstanding;
	int                       fail_count;

	// stimulus-side memory of each source's last timestamp, used to aim gaps
	logic [TS_W-1:0]  ts_hist  [256];
	bit               ts_known [256];
	logic [THR_W-1:0] thr_now = THR_RESET;
	bit               calm = 1'b0;
	int               ready_hold = 0;
	int               quiet = 0;

	source_feed_health_monitor u_top (.*);

	sfhm_checker u_checker (.*);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side: ready runs and stall bursts of random length alternate;
	// once calm is set the sink just stays ready
	always @(posedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (out_ready) begin
			if ($urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				ready_hold <= $urandom_range(0, 7);
			end
		end else begin
			out_ready <= 1'b1;
			ready_hold <= $urandom_range(0, 30);
		end
	end

	// hang detector: counts cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("source_feed_health_monitor regression: fail");
			$finish;
		end
	end

	function automatic logic [TS_W-1:0] rand63();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[TS_W-1:0];
	endfunction

	// uniform-ish value in [0, lim]
	function automatic logic [63:0] rand_upto(logic [63:0] lim);
		return {$urandom(), $urandom()} % (lim + 64'd1);
	endfunction

	// next timestamp for a source, aimed around the current stale threshold
	function automatic logic [TS_W-1:0] next_stamp(logic [SID_W-1:0] sid);
		logic [TS_W-1:0] prev;
		int pick;
		prev = ts_hist[sid];
		pick = $urandom_range(0, 99);
		if (!ts_known[sid] || pick >= 94)
			return rand63();
		// gap at or under the threshold: healthy
		if (pick < 40)
			return prev + TS_W'(rand_upto(64'(thr_now)));
		// a little over the threshold: stale
		if (pick < 62)
			return prev + TS_W'(thr_now) + TS_W'(64'd1 + rand_upto(64'd5000));
		// right on the boundary
		if (pick < 70)
			return prev + TS_W'(thr_now) + TS_W'($urandom_range(0, 1));
		// clock stepping back
		if (pick < 80)
			return prev - TS_W'(rand_upto(64'(thr_now) + 64'd1));
		// gaps past the signed 48-bit range, both ways
		if (pick < 87)
			return prev + TS_W'(GAP_SPAN + rand_upto(GAP_SPAN - 64'd1));
		return prev - TS_W'(GAP_SPAN + rand_upto(GAP_SPAN - 64'd1));
	endfunction

	// present one event beat and hold it until taken; valid is left high
	task automatic send_event(input logic [SID_W-1:0] sid, input logic [TS_W-1:0] ts,
			input logic sg, input logic du, input logic oo);
		in_valid <= 1'b1;
		source_id <= sid;
		timestamp_ns <= ts;
		seq_gap_flag <= sg;
		duplicate_flag <= du;
		out_of_order_flag <= oo;
		ts_hist[sid] = ts;
		ts_known[sid] = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop sending and wait for every outstanding result beat
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		thr_now = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [SID_W-1:0] pool [6];
		logic [SID_W-1:0] sid;
		logic [THR_W-1:0] thr_pick;
		int flag_pct;
		// every input known from time zero while reset is held
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		source_id = '0;
		timestamp_ns = '0;
		seq_gap_flag = 1'b0;
		duplicate_flag = 1'b0;
		out_of_order_flag = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed beats, threshold at its reset value of one second
		send_event(8'd0, '0, 1'b0, 1'b0, 1'b0);                    // first event, no gap
		send_event(8'd0, TS_W'(64'd1000000000), 1'b1, 1'b1, 1'b1); // gap equal to threshold
		send_event(8'd0, TS_W'(64'd2000000001), 1'b0, 1'b0, 1'b0); // one over: stale
		send_event(8'd0, TS_W'(64'd5), 1'b0, 1'b1, 1'b0);          // time going backwards
		send_event(8'd255, TS_MAX, 1'b1, 1'b0, 1'b1);              // top source, top stamp
		send_event(8'd255, '0, 1'b0, 1'b0, 1'b0);                  // huge negative gap, clamped
		send_event(8'd255, TS_MAX, 1'b0, 1'b1, 1'b1);              // huge positive gap, clamped
		send_event(8'd2, TS_P47, 1'b0, 1'b0, 1'b0);
		send_event(8'd2, '0, 1'b1, 1'b1, 1'b1);                    // back by exactly 2^47
		send_event(8'd2, TS_P47 - TS_W'(1), 1'b1, 1'b1, 1'b1);     // forward by 2^47 - 1
		send_event(8'd128, TS_W'(42), 1'b1, 1'b1, 1'b1);
		send_event(8'd128, TS_W'(42), 1'b1, 1'b1, 1'b1);           // zero gap, flag rates at one
		// run of stale events on one source: stale flag set, not usable
		for (int i = 1; i <= 7; i++)
			send_event(8'd7, TS_W'(64'd3000000000 * i), 1'b0, 1'b0, 1'b0);

		// random phases, each under its own threshold, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			case (ph)
				0: thr_pick = '0;
				1: thr_pick = '1;
				2: thr_pick = THR_W'(1000);
				3: thr_pick = THR_W'({$urandom(), $urandom()});
				4: thr_pick = THR_W'(1000000);
				default: thr_pick = THR_RESET;
			endcase
			write_threshold(thr_pick);
			// a handful of busy sources per phase so histories build up
			for (int k = 0; k < 6; k++)
				pool[k] = SID_W'($urandom_range(0, 255));
			flag_pct = $urandom_range(0, 100);
			// last phase runs with no idling on either side
			if (ph == 5)
				calm = 1'b1;
			for (int n = 0; n < 190; n++) begin
				if (!calm && $urandom_range(0, 3) == 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
				if ($urandom_range(0, 4) == 0)
					sid = SID_W'($urandom_range(0, 255));
				else
					sid = pool[$urandom_range(0, 5)];
				send_event(sid, next_stamp(sid),
					$urandom_range(0, 99) < flag_pct,
					$urandom_range(0, 99) < flag_pct,
					$urandom_range(0, 99) < flag_pct);
			end
		end

		// drain, then give a stray late beat time to show up
		wait_drained();
		repeat (80) @(posedge clk);
		if (fail_count == 0)
			$display("source_feed_health_monitor regression: pass");
		else
			$display("source_feed_health_monitor regression: fail");
		$finish;
	end

endmodule

### filelist.f
rtl/sfhm_pkg.sv
rtl/sfhm_ram.sv
rtl/sfhm_div.sv
rtl/source_feed_health_monitor.sv
test/sfhm_checker.sv
test/tb_top.sv
